// File: rtl/core/bctd_pkg.sv
// bctd_pkg: shared types for the BC1/BC3/BC5 texture block decoder.
// Format codes, channel words and the structs passed between pipeline stages.
// No dependencies.
package bctd_pkg;

  typedef enum logic [1:0] {
    FMT_BC1  = 2'd0,
    FMT_BC3  = 2'd1,
    FMT_BC5  = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic        last_row;
    logic [31:0] texel3_rgba;
    logic [31:0] texel2_rgba;
    logic [31:0] texel1_rgba;
    logic [31:0] texel0_rgba;
    logic [1:0]  row_index;
  } out_word_t;

  typedef struct packed {
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
  } rgb8_t;

  // endpoint stage -> palette stage
  typedef struct packed {
    fmt_t        fmt;
    logic        four_col;
    rgb8_t       e0;
    rgb8_t       e1;
    logic [31:0] col_idx;
    logic [63:0] ch0_blk;
    logic [63:0] ch1_blk;
  } ep_t;

  // palette stage -> column lanes
  typedef struct packed {
    fmt_t            fmt;
    logic [3:0][31:0] col_pal;
    logic [31:0]     col_idx;
    logic [7:0][7:0] ch0_pal;
    logic [7:0][7:0] ch1_pal;
    logic [47:0]     ch0_idx;
    logic [47:0]     ch1_idx;
  } pal_t;

endpackage

// File: rtl/core/bctd_endpoint.sv
// bctd_endpoint: first stage; picks the colour half and expands the 565 endpoints.
// Depends on bctd_pkg.
module bctd_endpoint (
  input  logic             clk,
  input  logic             load,
  input  bctd_pkg::fmt_t   fmt,
  input  bctd_pkg::in_word_t blk,
  output bctd_pkg::ep_t    ep
);
  import bctd_pkg::*;

  typedef logic [31:0][7:0] exp5_lut_t;
  typedef logic [63:0][7:0] exp6_lut_t;

  function automatic exp5_lut_t build_exp5();
    exp5_lut_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_lut_t build_exp6();
    exp6_lut_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam exp5_lut_t EXP5_LUT = build_exp5();
  localparam exp6_lut_t EXP6_LUT = build_exp6();

  logic [63:0] col_blk;
  logic [15:0] c0;
  logic [15:0] c1;
  logic        force4;
  ep_t         ep_nxt;
  ep_t         ep_r;

  always_comb begin
    case (fmt)
      FMT_BC3: begin
        col_blk = blk.block_high;
        force4  = 1'b1;
      end
      default: begin
        col_blk = blk.block_low;
        force4  = 1'b0;
      end
    endcase
    c0 = col_blk[15:0];
    c1 = col_blk[31:16];
    ep_nxt.fmt      = fmt;
    ep_nxt.four_col = force4 || (c0 > c1);
    ep_nxt.e0.red   = EXP5_LUT[c0[15:11]];
    ep_nxt.e0.grn   = EXP6_LUT[c0[10:5]];
    ep_nxt.e0.blu   = EXP5_LUT[c0[4:0]];
    ep_nxt.e1.red   = EXP5_LUT[c1[15:11]];
    ep_nxt.e1.grn   = EXP6_LUT[c1[10:5]];
    ep_nxt.e1.blu   = EXP5_LUT[c1[4:0]];
    ep_nxt.col_idx  = col_blk[63:32];
    ep_nxt.ch0_blk  = blk.block_low;
    ep_nxt.ch1_blk  = blk.block_high;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ep_r <= ep_nxt;
    end
  end

  assign ep = ep_r;

endmodule

// File: rtl/core/bctd_palette.sv
// bctd_palette: second stage; builds the colour palette and both channel palettes.
// Depends on bctd_pkg.
module bctd_palette (
  input  logic          clk,
  input  logic          load,
  input  bctd_pkg::ep_t ep,
  output bctd_pkg::pal_t pal
);
  import bctd_pkg::*;

  // truncating divides by reciprocal multiply, exact over the ranges used
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd2341;
    return p[21:14];
  endfunction

  function automatic logic [7:0] mix3(input logic [7:0] a, input logic [7:0] b);
    return div3(10'({a, 1'b0}) + 10'(b));
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  function automatic logic [7:0][7:0] chan_pal(input logic [7:0] a0, input logic [7:0] a1);
    logic [7:0][7:0] p;
    logic [10:0]     s;
    p[0] = a0;
    p[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        s = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        p[1 + i] = div7(s);
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        s = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        p[1 + i] = div5(s);
      end
      p[6] = 8'h00;
      p[7] = 8'hFF;
    end
    return p;
  endfunction

  pal_t pal_nxt;
  pal_t pal_r;

  always_comb begin
    pal_nxt.fmt        = ep.fmt;
    pal_nxt.col_pal[0] = {8'hFF, ep.e0};
    pal_nxt.col_pal[1] = {8'hFF, ep.e1};
    if (ep.four_col) begin
      pal_nxt.col_pal[2] = {8'hFF, mix3(ep.e0.blu, ep.e1.blu), mix3(ep.e0.grn, ep.e1.grn),
                            mix3(ep.e0.red, ep.e1.red)};
      pal_nxt.col_pal[3] = {8'hFF, mix3(ep.e1.blu, ep.e0.blu), mix3(ep.e1.grn, ep.e0.grn),
                            mix3(ep.e1.red, ep.e0.red)};
    end else begin
      pal_nxt.col_pal[2] = {8'hFF, avg2(ep.e0.blu, ep.e1.blu), avg2(ep.e0.grn, ep.e1.grn),
                            avg2(ep.e0.red, ep.e1.red)};
      pal_nxt.col_pal[3] = 32'h0;
    end
    pal_nxt.col_idx = ep.col_idx;
    pal_nxt.ch0_pal = chan_pal(ep.ch0_blk[7:0], ep.ch0_blk[15:8]);
    pal_nxt.ch1_pal = chan_pal(ep.ch1_blk[7:0], ep.ch1_blk[15:8]);
    pal_nxt.ch0_idx = ep.ch0_blk[63:16];
    pal_nxt.ch1_idx = ep.ch1_blk[63:16];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pal_r <= pal_nxt;
    end
  end

  assign pal = pal_r;

endmodule

// File: rtl/core/bctd_lane.sv
// bctd_lane: one column lane; looks up the texel of its column in the current row.
// Depends on bctd_pkg.
module bctd_lane (
  input  bctd_pkg::pal_t pal,
  input  logic [1:0]     row,
  input  logic [1:0]     lane_col,
  output logic [31:0]    texel
);
  import bctd_pkg::*;

  logic [3:0] k;
  logic [4:0] base2;
  logic [5:0] base3;
  logic [1:0] ci;
  logic [2:0] ai;
  logic [2:0] bi;

  always_comb begin
    k     = {row, lane_col};
    base2 = {k, 1'b0};
    base3 = ({2'b00, k} << 1) + {2'b00, k};
    ci    = pal.col_idx[base2 +: 2];
    ai    = pal.ch0_idx[base3 +: 3];
    bi    = pal.ch1_idx[base3 +: 3];
    case (pal.fmt)
      FMT_BC3: texel = {pal.ch0_pal[ai], pal.col_pal[ci][23:0]};
      FMT_BC5: texel = {8'hFF, 8'h80, pal.ch1_pal[bi], pal.ch0_pal[ai]};
      default: texel = pal.col_pal[ci];
    endcase
  end

endmodule

// File: rtl/core/bc_texture_block_decoder_top.sv
// bc_texture_block_decoder_top: BC1/BC3/BC5 block decoder, four column lanes.
// Row 0 is presented once the block word has passed the endpoint, palette and
// output registers, then one row per cycle while out_ready allows. New block
// words are accepted while the prior block is output. Sync active-low reset
// empties the pipeline and sets format BC1. Depends on bctd_pkg and submodules.
module bc_texture_block_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  bctd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output bctd_pkg::out_word_t out_word
);
  import bctd_pkg::*;

  fmt_t      block_format_r;
  logic      s1_vld_r;
  logic      s1_vld_nxt;
  logic      s2_vld_r;
  logic      s2_vld_nxt;
  logic [1:0] row_r;
  logic [1:0] row_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  logic      in_acc;
  logic      s2_adv;
  logic      s2_done;
  logic      s2_load;
  ep_t       ep;
  pal_t      pal;
  logic [3:0][31:0] texel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= FMT_BC1;
    end else if (cfg_we) begin
      block_format_r <= fmt_t'(cfg_wdata);
    end
  end

  always_comb begin
    s2_adv   = s2_vld_r && (!out_vld_r || out_ready);
    s2_done  = s2_adv && (row_r == 2'd3);
    s2_load  = s1_vld_r && (!s2_vld_r || s2_done);
    in_ready = !s1_vld_r || s2_load;
    in_acc   = in_valid && in_ready;

    s1_vld_nxt  = in_acc ? 1'b1 : (s2_load ? 1'b0 : s1_vld_r);
    s2_vld_nxt  = s2_load ? 1'b1 : (s2_done ? 1'b0 : s2_vld_r);
    row_nxt     = s2_load ? 2'd0 : (s2_adv ? row_r + 2'd1 : row_r);
    out_vld_nxt = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

    out_word_nxt.row_index   = row_r;
    out_word_nxt.texel0_rgba = texel[0];
    out_word_nxt.texel1_rgba = texel[1];
    out_word_nxt.texel2_rgba = texel[2];
    out_word_nxt.texel3_rgba = texel[3];
    out_word_nxt.last_row    = (row_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      row_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      row_r     <= row_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  bctd_endpoint u_endpoint (
    .clk  (clk),
    .load (in_acc),
    .fmt  (block_format_r),
    .blk  (in_word),
    .ep   (ep)
  );

  bctd_palette u_palette (
    .clk  (clk),
    .load (s2_load),
    .ep   (ep),
    .pal  (pal)
  );

  for (genvar gi = 0; gi < 4; gi++) begin : g_lane
    bctd_lane u_lane (
      .pal      (pal),
      .row      (row_r),
      .lane_col (2'(gi)),
      .texel    (texel[gi])
    );
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule
